[rtl/core/skt_pkg.sv]
// ----------------------------------------------------------------------------
// skt_pkg
// Shared constants, codes and control structs of the sorted key table.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  localparam int unsigned DEPTH_DEF     = 256;
  localparam int unsigned KEY_BITS_DEF  = 64;
  localparam int unsigned SIZE_BITS_DEF = 24;

  // fixed field widths at the ports
  localparam int unsigned OP_W      = 2;
  localparam int unsigned KEY_W     = 64;
  localparam int unsigned FSZ_W     = 25;
  localparam int unsigned OID_W     = 64;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CNT_OUT_W = 9;
  localparam int unsigned CONT_W    = 25;
  localparam int unsigned META_W    = 21;
  localparam int unsigned IN_DATA_W  = 184;
  localparam int unsigned OUT_DATA_W = 200;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 25;
  localparam logic [CFG_IDX_W-1:0] REG_CONTAINER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_METADATA  = 1'd1;

  localparam logic [CONT_W-1:0] CONT_RST = 25'd4194304;
  localparam logic [META_W-1:0] META_RST = 21'd4096;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic latch;     // take the request, init search window and shift pointer
    logic rd_mid;    // read probe entry
    logic ins_step;  // upper-bound search step
    logic srch_step; // exact search step
    logic sh_rd;     // read entry j-1
    logic sh_wr;     // write it to j
    logic ins_wr;    // write new entry, update counters
    logic found;     // lookup/delete hit on probed entry
    logic miss;
    logic full;
    logic clr;
    logic load;      // move result to output register
  } skt_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            srch_end;
    logic            key_eq;
    logic            sh_done;
  } skt_stat_t;

endpackage

`default_nettype wire

[rtl/core/sorted_key_table_with_delete_marks.sv]
// ----------------------------------------------------------------------------
// sorted_key_table_with_delete_marks
// Key-sorted entry table with insert, binary-search lookup, delete marks.
// ----------------------------------------------------------------------------
// A lookup or delete probes at most floor(log2(n))+1 entries; an insert probes
//   at most ceil(log2(n+1)) entries, then shifts the n-p entries above its slot p.
//   Each result goes through the result and output registers; a held output
//   stalls the request in its final state.
// One request at a time; the next is taken while a result waits in the output.
// Reset (sync, rst_n low): empty table, byte counters 4096, limit 4194304.
`default_nettype none

module sorted_key_table_with_delete_marks #(
  parameter int unsigned TABLE_DEPTH = skt_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BITS    = skt_pkg::KEY_BITS_DEF,
  parameter int unsigned SIZE_BITS   = skt_pkg::SIZE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // key[63:0] stored size[88:64] uncompressed size[113:89] origin_id[177:114]
  // indexed_flag[178] deleted_flag[179] include_deleted[180], zero pad
  input  wire logic [skt_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic [skt_pkg::OP_W-1:0]          in_tuser,   // opcode[1:0]
  // result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // hit_offset[24:0] hit stored size[49:25] hit uncompressed size[74:50]
  // hit_origin_id[138:75] hit_deleted[139] hit_indexed[140]
  // live_count[149:141] active_bytes[174:150] append_position[199:175]
  output logic      [skt_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic      [skt_pkg::STAT_W-1:0]        out_tuser,  // status[1:0]
  // register writes
  input  wire logic                              cfg_we,
  input  wire logic [skt_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [skt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  skt_pkg::skt_cmd_t  cmd;
  skt_pkg::skt_stat_t stat;

  logic [skt_pkg::FSZ_W-1:0]     o_off, o_isz, o_rsz, o_act, o_pos;
  logic [skt_pkg::OID_W-1:0]     o_oid;
  logic                          o_del, o_idx;
  logic [skt_pkg::CNT_OUT_W-1:0] o_live;

  skt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  skt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .SIZE_BITS   (SIZE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_op     (in_tuser),
    .in_key    (in_tdata[63:0]),
    .in_isz    (in_tdata[88:64]),
    .in_rsz    (in_tdata[113:89]),
    .in_oid    (in_tdata[177:114]),
    .in_idx    (in_tdata[178]),
    .in_del    (in_tdata[179]),
    .in_incl   (in_tdata[180]),
    .o_status  (out_tuser),
    .o_off     (o_off),
    .o_isz     (o_isz),
    .o_rsz     (o_rsz),
    .o_oid     (o_oid),
    .o_del     (o_del),
    .o_idx     (o_idx),
    .o_live    (o_live),
    .o_act     (o_act),
    .o_pos     (o_pos)
  );

  assign out_tdata = {o_pos, o_act, o_live, o_idx, o_del, o_oid, o_rsz, o_isz, o_off};

endmodule

`default_nettype wire

[rtl/core/skt_ram.sv]
// ----------------------------------------------------------------------------
// skt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ram #(
  parameter int unsigned W = 8,
  parameter int unsigned D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/skt_ctrl.sv]
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer: search, shift and write steps for one request at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  input  wire skt_pkg::skt_stat_t stat,
  output skt_pkg::skt_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_INS_CHK, S_I_RD, S_I_CMP, S_SH_RD, S_SH_WR,
    S_L_RD, S_L_CMP, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.op)
          skt_pkg::OP_INSERT: state_nxt = S_INS_CHK;
          skt_pkg::OP_LOOKUP, skt_pkg::OP_DELETE: state_nxt = S_L_RD;
          default: begin
            cmd.clr   = 1'b1;
            state_nxt = S_FIN;
          end
        endcase
      end
      S_INS_CHK: begin
        if (stat.full) begin
          cmd.full  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_I_RD;
        end
      end
      S_I_RD: begin
        if (stat.srch_end) begin
          state_nxt = S_SH_RD;
        end else begin
          cmd.rd_mid = 1'b1;
          state_nxt  = S_I_CMP;
        end
      end
      S_I_CMP: begin
        cmd.ins_step = 1'b1;
        state_nxt    = S_I_RD;
      end
      S_SH_RD: begin
        if (stat.sh_done) begin
          cmd.ins_wr = 1'b1;
          state_nxt  = S_FIN;
        end else begin
          cmd.sh_rd = 1'b1;
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.sh_wr = 1'b1;
        state_nxt = S_SH_RD;
      end
      S_L_RD: begin
        if (stat.srch_end) begin
          cmd.miss  = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.rd_mid = 1'b1;
          state_nxt  = S_L_CMP;
        end
      end
      S_L_CMP: begin
        if (stat.key_eq) begin
          cmd.found = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.srch_step = 1'b1;
          state_nxt     = S_L_RD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/skt_dp.sv]
// ----------------------------------------------------------------------------
// skt_dp
// Datapath: entry RAM, search window, counters, result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_dp #(
  parameter int unsigned TABLE_DEPTH = skt_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BITS    = skt_pkg::KEY_BITS_DEF,
  parameter int unsigned SIZE_BITS   = skt_pkg::SIZE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire skt_pkg::skt_cmd_t                cmd,
  output skt_pkg::skt_stat_t                    stat,
  input  wire logic                             cfg_we,
  input  wire logic [skt_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [skt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic [skt_pkg::OP_W-1:0]         in_op,
  input  wire logic [skt_pkg::KEY_W-1:0]        in_key,
  input  wire logic [skt_pkg::FSZ_W-1:0]        in_isz,
  input  wire logic [skt_pkg::FSZ_W-1:0]        in_rsz,
  input  wire logic [skt_pkg::OID_W-1:0]        in_oid,
  input  wire logic                             in_idx,
  input  wire logic                             in_del,
  input  wire logic                             in_incl,
  output logic      [skt_pkg::STAT_W-1:0]       o_status,
  output logic      [skt_pkg::FSZ_W-1:0]        o_off,
  output logic      [skt_pkg::FSZ_W-1:0]        o_isz,
  output logic      [skt_pkg::FSZ_W-1:0]        o_rsz,
  output logic      [skt_pkg::OID_W-1:0]        o_oid,
  output logic                                  o_del,
  output logic                                  o_idx,
  output logic      [skt_pkg::CNT_OUT_W-1:0]    o_live,
  output logic      [skt_pkg::FSZ_W-1:0]        o_act,
  output logic      [skt_pkg::FSZ_W-1:0]        o_pos
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = AW + 1;
  localparam int unsigned SZ   = SIZE_BITS + 1;
  localparam int unsigned CMPW = (SZ + 1 > skt_pkg::CONT_W) ? SZ + 1 : skt_pkg::CONT_W;
  // entry word, key in the low bits
  localparam int unsigned F_OFF = KEY_BITS;
  localparam int unsigned F_ISZ = F_OFF + SZ;
  localparam int unsigned F_RSZ = F_ISZ + SZ;
  localparam int unsigned F_DEL = F_RSZ + SZ;
  localparam int unsigned F_IDX = F_DEL + 1;
  localparam int unsigned F_OID = F_IDX + 1;
  localparam int unsigned EW    = F_OID + skt_pkg::OID_W;

  // latched request
  logic [skt_pkg::OP_W-1:0]  op_r;
  logic [KEY_BITS-1:0]       key_r;
  logic [SZ-1:0]             isz_r, rsz_r;
  logic [skt_pkg::OID_W-1:0] oid_r;
  logic                      idx_r, del_r, incl_r;

  // table control
  logic [CW-1:0] lo_r, hi_r, j_r, mid_r, n_r, live_r;
  logic [SZ-1:0] act_r, pos_r;
  logic [skt_pkg::CONT_W-1:0] cont_r;
  logic [skt_pkg::META_W-1:0] meta_r;

  // result
  logic [skt_pkg::STAT_W-1:0] res_st_r;
  logic [SZ-1:0]              res_off_r, res_isz_r, res_rsz_r;
  logic [skt_pkg::OID_W-1:0]  res_oid_r;
  logic                       res_del_r, res_idx_r;

  logic [EW-1:0] rdata, wdata;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [CW-1:0] mid, span;
  logic [KEY_BITS-1:0] rd_key;
  logic [SZ-1:0]       rd_isz;
  logic                rd_del;
  logic [CMPW-1:0]     fit_sum;
  logic [EW-1:0]       new_ent;
  logic                is_del_op;

  assign rd_key = rdata[KEY_BITS-1:0];
  assign rd_isz = rdata[F_ISZ +: SZ];
  assign rd_del = rdata[F_DEL];
  assign is_del_op = (op_r == skt_pkg::OP_DELETE);

  // insert: upper bound over [lo,hi); lookup: midpoint over [lo,hi-1]
  assign span = (op_r == skt_pkg::OP_INSERT) ? (hi_r - lo_r) : (hi_r - lo_r - CW'(1));
  assign mid  = lo_r + (span >> 1);

  assign fit_sum = CMPW'(pos_r) + CMPW'(isz_r);
  assign new_ent = {oid_r, idx_r, del_r, rsz_r, isz_r, pos_r, key_r};

  assign stat.op       = op_r;
  assign stat.full     = (n_r == CW'(TABLE_DEPTH)) || (fit_sum > CMPW'(cont_r));
  assign stat.srch_end = (lo_r >= hi_r);
  assign stat.key_eq   = (rd_key == key_r);
  assign stat.sh_done  = (j_r == lo_r);

  always_comb begin
    raddr = cmd.sh_rd ? AW'(j_r - CW'(1)) : AW'(mid);
    we    = cmd.sh_wr || cmd.ins_wr || (cmd.found && is_del_op);
    waddr = AW'(mid_r);
    wdata = rdata;
    if (cmd.sh_wr) begin
      waddr = AW'(j_r);
    end else if (cmd.ins_wr) begin
      waddr = AW'(lo_r);
      wdata = new_ent;
    end else begin
      wdata[F_DEL] = 1'b1;
    end
  end

  skt_ram #(.W(EW), .D(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // counters and limits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cont_r <= skt_pkg::CONT_RST;
      meta_r <= skt_pkg::META_RST;
      n_r    <= '0;
      live_r <= '0;
      act_r  <= SZ'(skt_pkg::META_RST);
      pos_r  <= SZ'(skt_pkg::META_RST);
    end else if (cfg_we) begin
      if (cfg_idx == skt_pkg::REG_CONTAINER) begin
        cont_r <= cfg_wdata;
      end else begin
        meta_r <= skt_pkg::META_W'(cfg_wdata);
        n_r    <= '0;
        live_r <= '0;
        act_r  <= SZ'(skt_pkg::META_W'(cfg_wdata));
        pos_r  <= SZ'(skt_pkg::META_W'(cfg_wdata));
      end
    end else if (cmd.clr) begin
      n_r    <= '0;
      live_r <= '0;
      act_r  <= SZ'(meta_r);
      pos_r  <= SZ'(meta_r);
    end else if (cmd.ins_wr) begin
      n_r   <= n_r + CW'(1);
      pos_r <= pos_r + isz_r;
      if (!del_r) begin
        live_r <= live_r + CW'(1);
        act_r  <= act_r + isz_r;
      end
    end else if (cmd.found && is_del_op && !rd_del) begin
      act_r <= act_r - rd_isz;
      if (live_r != '0) begin
        live_r <= live_r - CW'(1);
      end
    end
  end

  // request, search window and result
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_op;
      key_r  <= KEY_BITS'(in_key);
      isz_r  <= SZ'(in_isz);
      rsz_r  <= SZ'(in_rsz);
      oid_r  <= in_oid;
      idx_r  <= in_idx;
      del_r  <= in_del;
      incl_r <= in_incl;
      lo_r   <= '0;
      hi_r   <= n_r;
      j_r    <= n_r;
    end
    if (cmd.rd_mid) begin
      mid_r <= mid;
    end
    if (cmd.ins_step) begin
      if (rd_key <= key_r) lo_r <= mid_r + CW'(1);
      else                 hi_r <= mid_r;
    end
    if (cmd.srch_step) begin
      if (rd_key < key_r) lo_r <= mid_r + CW'(1);
      else                hi_r <= mid_r;
    end
    if (cmd.sh_wr) begin
      j_r <= j_r - CW'(1);
    end
    if (cmd.clr || cmd.miss || cmd.full) begin
      res_st_r  <= cmd.miss ? skt_pkg::ST_MISS :
                   (cmd.full ? skt_pkg::ST_FULL : skt_pkg::ST_OK);
      res_off_r <= '0;
      res_isz_r <= '0;
      res_rsz_r <= '0;
      res_oid_r <= '0;
      res_del_r <= 1'b0;
      res_idx_r <= 1'b0;
    end
    if (cmd.ins_wr) begin
      res_st_r  <= skt_pkg::ST_OK;
      res_off_r <= pos_r;
      res_isz_r <= isz_r;
      res_rsz_r <= rsz_r;
      res_oid_r <= oid_r;
      res_del_r <= del_r;
      res_idx_r <= idx_r;
    end
    if (cmd.found) begin
      // deleted entry stays hidden from a plain lookup
      if (!is_del_op && rd_del && !incl_r) begin
        res_st_r  <= skt_pkg::ST_MISS;
        res_off_r <= '0;
        res_isz_r <= '0;
        res_rsz_r <= '0;
        res_oid_r <= '0;
        res_del_r <= 1'b0;
        res_idx_r <= 1'b0;
      end else begin
        res_st_r  <= skt_pkg::ST_OK;
        res_off_r <= rdata[F_OFF +: SZ];
        res_isz_r <= rd_isz;
        res_rsz_r <= rdata[F_RSZ +: SZ];
        res_oid_r <= rdata[F_OID +: skt_pkg::OID_W];
        res_del_r <= rd_del || is_del_op;
        res_idx_r <= rdata[F_IDX];
      end
    end
    if (cmd.load) begin
      o_status <= res_st_r;
      o_off    <= skt_pkg::FSZ_W'(res_off_r);
      o_isz    <= skt_pkg::FSZ_W'(res_isz_r);
      o_rsz    <= skt_pkg::FSZ_W'(res_rsz_r);
      o_oid    <= res_oid_r;
      o_del    <= res_del_r;
      o_idx    <= res_idx_r;
      o_live   <= skt_pkg::CNT_OUT_W'(live_r);
      o_act    <= skt_pkg::FSZ_W'(act_r);
      o_pos    <= skt_pkg::FSZ_W'(pos_r);
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted key table: requests go in on the stream
// input, each result is checked field by field against an in-bench predictor
// of the sorted table, under several idle and stall patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;
  import skt_pkg::*;

  localparam int DEPTH = 256;

  typedef struct packed {
    logic [1:0]  status;
    logic [24:0] offset;
    logic [24:0] isz;
    logic [24:0] rsz;
    logic [63:0] oid;
    logic        del;
    logic        idx;
    logic [8:0]  live;
    logic [24:0] active;
    logic [24:0] pos;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [OP_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  sorted_key_table_with_delete_marks u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata),   // key, sizes, origin_id, flags
    .in_tuser(in_tuser),   // opcode
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), // hit fields, live_count, active_bytes, position
    .out_tuser(out_tuser), // status
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  initial forever #4 clk = ~clk;

  initial begin
    #40ms;
    $display("tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predicted table contents
  // ---------------------------------------------------------------------------
  logic [63:0] tbl_key [DEPTH];
  logic [24:0] tbl_off [DEPTH];
  logic [24:0] tbl_isz [DEPTH];
  logic [24:0] tbl_rsz [DEPTH];
  logic [63:0] tbl_oid [DEPTH];
  logic        tbl_del [DEPTH];
  logic        tbl_idx [DEPTH];
  int          tbl_count;
  logic [8:0]  tbl_live;
  logic [24:0] tbl_active;
  logic [24:0] tbl_pos;
  logic [24:0] lim_container;
  logic [20:0] meta_size;

  table_result_t pending_results[$];
  int errors = 0;

  // sender idle and receiver stall percentages, set per phase
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;  // request a long receiver hold-off

  function automatic void table_clear();
    tbl_count  = 0;
    tbl_live   = '0;
    tbl_active = 25'(meta_size);
    tbl_pos    = 25'(meta_size);
  endfunction

  // exact midpoint search, first matching probe
  function automatic int probe_key(logic [63:0] k);
    int lo, hi, mid;
    lo = 0;
    hi = tbl_count - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_key[mid] < k) lo = mid + 1;
      else if (tbl_key[mid] > k) hi = mid - 1;
      else return mid;
    end
    return -1;
  endfunction

  function automatic table_result_t predict_table_op(logic [1:0] op, logic [63:0] k,
      logic [24:0] isz, logic [24:0] rsz, logic [63:0] oid, logic idxf, logic delf,
      logic incl);
    table_result_t r;
    int p, i;
    logic hit;
    r = '0;
    hit = 1'b0;
    i = -1;
    case (op)
      OP_INSERT: begin
        if (tbl_count >= DEPTH || 64'(tbl_pos) + 64'(isz) > 64'(lim_container)) begin
          r.status = ST_FULL;
        end else begin
          p = 0;
          while (p < tbl_count && tbl_key[p] <= k) p++;
          for (int j = tbl_count; j > p; j--) begin
            tbl_key[j] = tbl_key[j-1]; tbl_off[j] = tbl_off[j-1];
            tbl_isz[j] = tbl_isz[j-1]; tbl_rsz[j] = tbl_rsz[j-1];
            tbl_oid[j] = tbl_oid[j-1]; tbl_del[j] = tbl_del[j-1];
            tbl_idx[j] = tbl_idx[j-1];
          end
          tbl_key[p] = k; tbl_off[p] = tbl_pos; tbl_isz[p] = isz; tbl_rsz[p] = rsz;
          tbl_oid[p] = oid; tbl_del[p] = delf; tbl_idx[p] = idxf;
          tbl_count++;
          if (!delf) begin
            tbl_live++;
            tbl_active = tbl_active + isz;
          end
          tbl_pos = tbl_pos + isz;
          r.status = ST_OK;
          hit = 1'b1;
          i = p;
        end
      end
      OP_LOOKUP: begin
        i = probe_key(k);
        if (i < 0 || (tbl_del[i] && !incl)) r.status = ST_MISS;
        else begin r.status = ST_OK; hit = 1'b1; end
      end
      OP_DELETE: begin
        i = probe_key(k);
        if (i < 0) r.status = ST_MISS;
        else begin
          if (!tbl_del[i]) begin
            tbl_del[i] = 1'b1;
            tbl_active = tbl_active - tbl_isz[i];
            if (tbl_live > 0) tbl_live--;
          end
          r.status = ST_OK;
          hit = 1'b1;
        end
      end
      default: begin
        table_clear();
        r.status = ST_OK;
      end
    endcase
    if (hit) begin
      r.offset = tbl_off[i]; r.isz = tbl_isz[i]; r.rsz = tbl_rsz[i];
      r.oid = tbl_oid[i]; r.del = tbl_del[i]; r.idx = tbl_idx[i];
    end
    r.live = tbl_live;
    r.active = tbl_active;
    r.pos = tbl_pos;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request sender. Ready is stable between edges, so it is sampled at the
  // falling edge ahead of the edge that would take the request.
  // ---------------------------------------------------------------------------
  task automatic send_request(logic [1:0] op, logic [63:0] k, logic [24:0] isz,
      logic [24:0] rsz, logic [63:0] oid, logic idxf, logic delf, logic incl);
    logic rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b0, incl, delf, idxf, oid, rsz, isz, k};
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
    pending_results.insert(pending_results.size(),
                           predict_table_op(op, k, isz, rsz, oid, idxf, delf, incl));
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // registers only change with the block idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    stop_sending();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CONTAINER) lim_container = val;
    else begin
      meta_size = val[20:0];
      table_clear();
    end
  endtask

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        hold_cnt = hold_len;
        hold_len = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic cmp_field(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, e, a);
    end
  endtask

  // result checker: out side is stable at the falling edge
  always @(negedge clk) begin
    table_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual status %0h data %0h",
                 $time, out_tuser, out_tdata);
      end else begin
        e = pending_results.pop_front();
        cmp_field("status",          64'(e.status), 64'(out_tuser));
        cmp_field("hit_offset",      64'(e.offset), 64'(out_tdata[24:0]));
        cmp_field("hit_stored_size", 64'(e.isz),    64'(out_tdata[49:25]));
        cmp_field("hit_full_size",   64'(e.rsz),    64'(out_tdata[74:50]));
        cmp_field("hit_origin_id",   e.oid,         out_tdata[138:75]);
        cmp_field("hit_deleted",     64'(e.del),    64'(out_tdata[139]));
        cmp_field("hit_indexed",     64'(e.idx),    64'(out_tdata[140]));
        cmp_field("live_count",      64'(e.live),   64'(out_tdata[149:141]));
        cmp_field("active_bytes",    64'(e.active), 64'(out_tdata[174:150]));
        cmp_field("append_position", 64'(e.pos),    64'(out_tdata[199:175]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Random traffic: small key pool so hits, duplicates and hidden entries occur
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] pick_key();
    case ($urandom_range(9))
      0: return 64'h0;
      1: return '1;
      2: return {$urandom, $urandom};
      default: return 64'($urandom_range(23)) << ($urandom_range(1) ? 60 : 0);
    endcase
  endfunction

  function automatic logic [24:0] pick_size();
    case ($urandom_range(19))
      0: return 25'($urandom);
      1: return '0;
      default: return 25'($urandom_range(4095));
    endcase
  endfunction

  task automatic random_traffic(int n);
    int r;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      op = (r < 40) ? OP_INSERT : (r < 72) ? OP_LOOKUP : (r < 97) ? OP_DELETE : OP_CLEAR;
      send_request(op, pick_key(), pick_size(), 25'($urandom), {$urandom, $urandom},
                   1'($urandom), ($urandom_range(7) == 0), 1'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_request(OP_LOOKUP, 64'h5, '0, '0, '0, 1'b0, 1'b0, 1'b1);   // empty table miss
    send_request(OP_DELETE, 64'h5, '0, '0, '0, 1'b0, 1'b0, 1'b0);   // absent key
    send_request(OP_INSERT, 64'h0, 25'd100, '1, '1, 1'b1, 1'b0, 1'b0);
    send_request(OP_INSERT, '1, 25'd0, 25'd0, 64'h0, 1'b0, 1'b0, 1'b1);
    send_request(OP_INSERT, 64'h7, 25'd10, 25'd20, 64'hA5A5, 1'b1, 1'b0, 1'b0);
    send_request(OP_INSERT, 64'h7, 25'd11, 25'd21, 64'h5A5A, 1'b0, 1'b0, 1'b0); // duplicate
    send_request(OP_INSERT, 64'h7, 25'd12, 25'd22, 64'h1234, 1'b0, 1'b1, 1'b0); // born deleted
    send_request(OP_LOOKUP, 64'h7, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_LOOKUP, '1, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_LOOKUP, 64'h0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_DELETE, 64'h7, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_DELETE, 64'h7, '0, '0, '0, 1'b0, 1'b0, 1'b0);   // may hit deleted one
    send_request(OP_LOOKUP, 64'h7, '0, '0, '0, 1'b0, 1'b0, 1'b0);   // hidden entry
    send_request(OP_LOOKUP, 64'h7, '0, '0, '0, 1'b0, 1'b0, 1'b1);   // include deleted
    send_request(OP_DELETE, 64'h0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_LOOKUP, 64'h0, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    // container limit: exact fit, then one byte over
    send_request(OP_INSERT, 64'h9, 25'(CONT_RST) - tbl_pos, '0, '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_INSERT, 64'h9, 25'd1, '0, '0, 1'b0, 1'b0, 1'b0);
    send_request(OP_INSERT, 64'h9, '1, '1, '1, 1'b1, 1'b1, 1'b1);   // oversize
    send_request(OP_CLEAR, '1, '1, '1, '1, 1'b1, 1'b1, 1'b1);
    send_request(OP_LOOKUP, 64'h9, '0, '0, '0, 1'b0, 1'b0, 1'b1);
  endtask

  task automatic test_table_full();
    write_reg(REG_CONTAINER, 25'd16777216);
    write_reg(REG_METADATA, 25'd0);
    for (int i = 0; i < DEPTH + 2; i++)
      send_request(OP_INSERT, 64'($urandom_range(300)), 25'($urandom_range(64)),
                   25'($urandom), {$urandom, $urandom}, 1'($urandom), 1'($urandom), 1'b0);
    for (int i = 0; i < 20; i++)
      send_request(OP_LOOKUP, 64'($urandom_range(300)), '0, '0, '0, 1'b0, 1'b0,
                   1'($urandom));
    send_request(OP_CLEAR, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_config_extremes();
    write_reg(REG_METADATA, 25'd1048576);
    write_reg(REG_CONTAINER, 25'd4096);      // below metadata: every insert full
    random_traffic(25);
    write_reg(REG_METADATA, 25'd0);
    random_traffic(40);
    write_reg(REG_CONTAINER, 25'd16777216);
    write_reg(REG_METADATA, 25'h1FFFFF);
    random_traffic(60);
    write_reg(REG_CONTAINER, CONT_RST);
    write_reg(REG_METADATA, 25'(META_RST));
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  random_traffic(350);
    send_idle_pct = 63; recv_stall_pct = 0;  random_traffic(300);
    send_idle_pct = 0;  recv_stall_pct = 63; random_traffic(300);
    send_idle_pct = 17; recv_stall_pct = 17; random_traffic(300);
    send_idle_pct = 0;  recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    hold_len = 3000;
    random_traffic(30);
  endtask

  initial begin
    lim_container = CONT_RST;
    meta_size = META_RST;
    table_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_table_full();
    test_random_phases();
    test_backpressure();
    stop_sending();
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/core/skt_pkg.sv
rtl/core/skt_ram.sv
rtl/core/skt_ctrl.sv
rtl/core/skt_dp.sv
rtl/core/sorted_key_table_with_delete_marks.sv
tb/sv/tb.sv
